/* rtl/lgw_pkg.sv */
package lgw_pkg;

    localparam int ORDER_W = 5;
    localparam int ROW_W   = 17;
    localparam int COORD_W = 32;
    localparam int IDX_W   = 16;
    localparam int TAP_W   = 4;
    localparam int WGT_W   = 32;
    localparam int NUM_W   = 62;
    localparam int DEN_W   = 41;
    localparam int DIV_W   = 63;
    localparam int CFG_IDX_W = 1;

    localparam logic [NUM_W-1:0] NUM_CAP = {NUM_W{1'b1}};
    localparam logic [DEN_W-1:0] DEN_CAP = {DEN_W{1'b1}};
    localparam logic [NUM_W-1:0] ONE_Q30 = NUM_W'(64'd1 << 30);
    localparam logic [WGT_W-1:0] ONE_Q24 = WGT_W'(32'd1 << 24);
    localparam logic [ROW_W-1:0] ROW_MAX = 17'd65536;
    localparam logic [ORDER_W-1:0] ORDER_RST = 5'd4;
    localparam logic [ROW_W-1:0] ROW_RST = 17'd256;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW   = 1'b1;

    localparam logic [1:0] KIND_TAP   = 2'd0;
    localparam logic [1:0] KIND_EXACT = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    typedef struct packed {
        logic take;
        logic setup1;
        logic setup2;
        logic tap_init;
        logic mul_hi;
        logic mul_lo;
        logic mul_acc;
        logic skip;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic single;
        logic skip;
        logic i_last;
        logic div_done;
        logic out_free;
        logic j_last;
    } t_sts;

endpackage

/* rtl/lgw_ctrl.sv */
module lgw_ctrl
    import lgw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SET1  = 4'd1;
    localparam logic [3:0] S_SET2  = 4'd2;
    localparam logic [3:0] S_TINIT = 4'd3;
    localparam logic [3:0] S_MSEL  = 4'd4;
    localparam logic [3:0] S_MHI   = 4'd5;
    localparam logic [3:0] S_MLO   = 4'd6;
    localparam logic [3:0] S_MACC  = 4'd7;
    localparam logic [3:0] S_DINIT = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_KIND  = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_SET1;
                end
            end
            S_SET1: begin
                o_cmd.setup1 = 1'b1;
                n_state = S_SET2;
            end
            S_SET2: begin
                o_cmd.setup2 = 1'b1;
                n_state = S_KIND;
            end
            S_KIND: begin
                // item kind is registered by now
                n_state = i_sts.single ? S_OUT : S_TINIT;
            end
            S_TINIT: begin
                o_cmd.tap_init = 1'b1;
                n_state = S_MSEL;
            end
            S_MSEL: begin
                if (i_sts.skip) begin
                    o_cmd.skip = 1'b1;
                    if (i_sts.i_last) n_state = S_DINIT;
                end else begin
                    n_state = S_MHI;
                end
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MACC;
            end
            S_MACC: begin
                o_cmd.mul_acc = 1'b1;
                n_state = i_sts.i_last ? S_DINIT : S_MSEL;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = (i_sts.single || i_sts.j_last) ? S_IDLE : S_TINIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

/* rtl/lgw_dp.sv */
module lgw_dp
    import lgw_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ROW_W-1:0]           i_cfg_data,
    input  logic signed [COORD_W-1:0]  i_coord,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic [IDX_W-1:0]           o_first_index,
    output logic [TAP_W-1:0]           o_tap,
    output logic signed [WGT_W-1:0]    o_weight,
    output logic                       o_none_in_range,
    output logic                       o_last
);

    localparam int QW  = $clog2(MAX_ORDER + 1);
    localparam int JW  = $clog2(MAX_ORDER);
    localparam int KW  = QW + 1;
    localparam int TW  = KW + 18;
    localparam int MW  = TW - 1;
    localparam int PHW = 30 + MW;
    localparam int PLW = 32 + MW;

    // configuration
    logic [ORDER_W-1:0] r_order;
    logic [ROW_W-1:0]   r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RST;
            r_row   <= ROW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORDER: r_order <= i_cfg_data[ORDER_W-1:0];
                REG_ROW:   r_row   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    logic [QW-1:0] q, qm1;
    logic signed [KW-1:0] k_lo, k_hi;
    logic [ROW_W-1:0] dim;

    always_comb begin
        if (r_order == '0) q = QW'(1);
        else if (int'(r_order) > MAX_ORDER) q = QW'(MAX_ORDER);
        else q = QW'(r_order);
        qm1  = q - QW'(1);
        k_lo = -$signed({1'b0, qm1 >> 1});
        k_hi = k_lo + $signed({1'b0, qm1});
        dim  = (r_row > ROW_MAX) ? ROW_MAX : r_row;
    end

    // coordinate set-up
    logic [COORD_W-1:0]  r_coord;
    logic signed [17:0]  r_fl, r_x;
    logic signed [16:0]  r_idx;
    logic                r_exact;
    logic [1:0]          r_kind;
    logic [IDX_W-1:0]    r_d1;
    logic [JW-1:0]       r_j, r_jlast, r_n, r_i;

    logic signed [33:0] c34, base;
    logic signed [19:0] fl20, kl20, kh20, d1raw, d2raw, d1, d2, dimm1, js, jl;
    logic               in_row;

    always_comb begin
        c34   = $signed({{2{r_coord[COORD_W-1]}}, r_coord}) - 34'sd65536;
        base  = q[0] ? c34 + 34'sd32768 : c34;
        fl20  = 20'(r_fl);
        kl20  = 20'(k_lo);
        kh20  = 20'(k_hi);
        d1raw = fl20 + kl20;
        d2raw = fl20 + kh20;
        dimm1 = $signed({3'b000, dim}) - 20'sd1;
        d1    = d1raw[19] ? 20'sd0 : d1raw;
        d2    = (d2raw > dimm1) ? dimm1 : d2raw;
        js    = d1 - fl20 - kl20;
        jl    = d2 - fl20 - kl20;
        in_row = !r_idx[16] && ({1'b0, r_idx[15:0]} < dim);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_coord <= i_coord;
        if (i_cmd.setup1) begin
            r_fl    <= base[33:16];
            r_x     <= 18'(c34 - {base[33:16], 16'b0});
            r_idx   <= c34[32:16];
            r_exact <= (r_coord[15:0] == '0);
        end
        if (i_cmd.setup2) begin
            r_n     <= '0;
            r_j     <= JW'(js);
            r_jlast <= JW'(jl);
            if (r_exact) begin
                r_kind <= in_row ? KIND_EXACT : KIND_NONE;
                r_d1   <= r_idx[15:0];
            end else begin
                r_kind <= (d2 < d1) ? KIND_NONE : KIND_TAP;
                r_d1   <= d1[IDX_W-1:0];
            end
        end else if (i_cmd.load_out) begin
            r_j <= r_j + JW'(1);
            r_n <= r_n + JW'(1);
        end
    end

    // product of factors, one factor per pass through the multiplier
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [PHW-1:0]   r_ph;
    logic [PLW-1:0]   r_pl;

    logic signed [KW-1:0] m;
    logic signed [TW-1:0] t;
    logic [MW-1:0]        tmag;
    logic [JW-1:0]        f;
    logic [DEN_W+JW-1:0]  dprod;
    logic [PLW:0]         plr;
    logic [PHW+16:0]      racc;
    logic                 ph_big;

    always_comb begin
        m     = k_lo + $signed(KW'(r_i));
        t     = TW'(r_x) - (TW'(m) <<< 16);
        tmag  = t[TW-1] ? MW'(-t) : MW'(t);
        f     = (r_j > r_i) ? r_j - r_i : r_i - r_j;
        dprod = r_den * f;
        plr   = {1'b0, r_pl} + (PLW+1)'(32'h8000);
        racc  = {1'b0, r_ph, 16'b0} + (PHW+17)'(plr >> 16);
        ph_big = |r_ph[PHW-1:46];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_init) begin
            r_num <= ONE_Q30;
            r_den <= DEN_W'(1);
            r_neg <= 1'b0;
            r_i   <= '0;
        end
        if (i_cmd.skip) r_i <= r_i + JW'(1);
        if (i_cmd.mul_hi) begin
            r_ph  <= r_num[NUM_W-1:32] * tmag;
            r_den <= (dprod > (DEN_W+JW)'(DEN_CAP)) ? DEN_CAP : DEN_W'(dprod);
            r_neg <= r_neg ^ t[TW-1] ^ (r_i > r_j);
        end
        if (i_cmd.mul_lo) r_pl <= r_num[31:0] * tmag;
        if (i_cmd.mul_acc) begin
            r_num <= (ph_big || racc > (PHW+17)'(NUM_CAP)) ? NUM_CAP : NUM_W'(racc);
            r_i   <= r_i + JW'(1);
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [DIV_W-1:0] r_dd;
    logic [DEN_W+6:0] r_rem;
    logic [31:0]      r_q;
    logic             r_ovf;
    logic [5:0]       r_dcnt;
    logic [DEN_W+7:0] rs;
    logic [DEN_W+6:0] dv;
    logic             ge;

    always_comb begin
        dv = {1'b0, r_den, 6'b0};
        rs = {r_rem, r_dd[DIV_W-1]};
        ge = rs >= {1'b0, dv};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dd   <= {1'b0, r_num} + DIV_W'({r_den, 5'b0});
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dd   <= r_dd << 1;
            r_rem  <= ge ? (DEN_W+7)'(rs - {1'b0, dv}) : (DEN_W+7)'(rs);
            r_q    <= {r_q[30:0], ge};
            r_ovf  <= r_ovf | r_q[31];
            r_dcnt <= r_dcnt + 6'd1;
        end
    end

    logic [WGT_W-1:0] wmag, wgt;

    always_comb begin
        if (r_neg) begin
            wmag = (r_ovf || r_q > 32'h8000_0000) ? 32'h8000_0000 : r_q;
            wgt  = 32'd0 - wmag;
        end else begin
            wmag = (r_ovf || r_q[31]) ? 32'h7FFF_FFFF : r_q;
            wgt  = wmag;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (r_kind)
                KIND_TAP: begin
                    o_first_index   <= r_d1;
                    o_tap           <= TAP_W'(r_n);
                    o_weight        <= wgt;
                    o_none_in_range <= 1'b0;
                    o_last          <= (r_j == r_jlast);
                end
                KIND_EXACT: begin
                    o_first_index   <= r_d1;
                    o_tap           <= '0;
                    o_weight        <= ONE_Q24;
                    o_none_in_range <= 1'b0;
                    o_last          <= 1'b1;
                end
                default: begin
                    o_first_index   <= '0;
                    o_tap           <= '0;
                    o_weight        <= '0;
                    o_none_in_range <= 1'b1;
                    o_last          <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.single   = (r_kind != KIND_TAP);
        o_sts.skip     = (r_i == r_j);
        o_sts.i_last   = (r_i == JW'(qm1));
        o_sts.div_done = (r_dcnt == 6'(DIV_W - 1));
        o_sts.out_free = !o_valid || i_ready;
        o_sts.j_last   = (r_j == r_jlast);
    end

endmodule

/* rtl/lagrange_interp_weights_top.sv */
// lagrange interpolation weight generator
// input channel: i_valid / o_ready with i_coord, a 1-based Q16.16 position
// output channel: o_valid / i_ready with first_index, tap, weight (Q8.24),
//   none_in_range and last; one item per in-row tap, last marks the final one
// config: i_cfg_we writes order (index 0) or row_length (index 1) at once
// one coordinate is handled at a time; o_ready is high only when idle
// exact or out-of-row coordinates: result loaded after SET1, SET2 and KIND
// each tap: per numerator factor, a select, high and low partial products
//   and an accumulate on the multiplier; a skip for the own tap; tap and
//   divider set-up; the bit-serial divider; then loading the result
// whole coordinate: set-up states SET1, SET2 and KIND, then each tap in turn,
//   divider dominated
// a result waits in the output register while i_ready is low; the next tap
//   is computed meanwhile and held until the register frees up
// reset sets order 4, row_length 256 and empties the output register
module lagrange_interp_weights_top
    import lgw_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [COORD_W-1:0]  i_coord,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [IDX_W-1:0]           o_first_index,
    output logic [TAP_W-1:0]           o_tap,
    output logic signed [WGT_W-1:0]    o_weight,
    output logic                       o_none_in_range,
    output logic                       o_last,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ROW_W-1:0]           i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    lgw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    lgw_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_coord         (i_coord),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_first_index   (o_first_index),
        .o_tap           (o_tap),
        .o_weight        (o_weight),
        .o_none_in_range (o_none_in_range),
        .o_last          (o_last)
    );

endmodule

/* rtl/lgw_chk.sv */
module lgw_chk
    import lgw_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [IDX_W-1:0]          o_first_index,
    input logic [TAP_W-1:0]          o_tap,
    input logic signed [WGT_W-1:0]   o_weight,
    input logic                      o_none_in_range,
    input logic                      o_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_weight) && $stable(o_tap)
            && $stable(o_first_index) && $stable(o_last))
        else $error("stalled result changed");

    // none-in-range item is last and carries zero index, tap and weight
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_none_in_range |-> o_last && o_weight == 0 && o_tap == 0
            && o_first_index == 0)
        else $error("none_in_range item malformed");

    // an unfinished item keeps the input closed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input open mid item");

    // one item at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

endmodule

bind lagrange_interp_weights_top lgw_chk u_lgw_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_first_index   (o_first_index),
    .o_tap           (o_tap),
    .o_weight        (o_weight),
    .o_none_in_range (o_none_in_range),
    .o_last          (o_last)
);

/* tb/sv/lagrange_interp_weights_top_tb.sv */
module lagrange_interp_weights_top_tb
    import lgw_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TAPS_MAX    = 16;
    localparam longint CYCLE_CAP = 4000000;

    typedef struct packed {
        bit [15:0] first_index;
        bit [3:0]  tap;
        bit [31:0] weight;
        bit        none_in_range;
        bit        last;
    } weight_item_t;

    class weight_board;
        weight_item_t pending[$];
        longint       den_tab[TAPS_MAX];
        longint       taps, k_first, k_final;
        bit [16:0]    row_len;
        int           errors;

        function new();
            errors  = 0;
            row_len = ROW_RST;
            set_order(ORDER_RST);
        endfunction

        function void set_order(bit [4:0] v);
            longint k, m;
            bit [63:0] mag;
            bit neg;
            taps = (v == 0) ? 1 : v;
            if (taps > TAPS_MAX) taps = TAPS_MAX;
            if (taps % 2 != 0) begin
                k_first = -(taps - 1) / 2;
                k_final = (taps - 1) / 2;
            end else begin
                k_first = -(taps - 2) / 2;
                k_final = taps / 2;
            end
            for (k = k_first; k <= k_final; k++) begin
                mag = 1;
                neg = 0;
                for (m = k_first; m <= k_final; m++) begin
                    if (m != k) begin
                        if (m > k) neg = !neg;
                        mag = mag * ((k > m) ? (k - m) : (m - k));
                        if (mag > 64'(DEN_CAP)) mag = 64'(DEN_CAP);
                    end
                end
                den_tab[k - k_first] = neg ? -longint'(mag) : longint'(mag);
            end
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [16:0] val);
            if (idx == REG_ORDER) set_order(val[4:0]);
            else row_len = val;
        endfunction

        // Q.30 magnitude times Q16.16 magnitude, rounded, saturating
        function bit [63:0] scale_q16(bit [63:0] a, bit [63:0] b);
            bit [63:0] ph, r;
            ph = (a >> 32) * b;
            if (ph >= (64'd1 << 46)) return 64'(NUM_CAP);
            r = (ph << 16) + (((a & 64'hFFFF_FFFF) * b + 64'h8000) >> 16);
            return (r > 64'(NUM_CAP)) ? 64'(NUM_CAP) : r;
        endfunction

        function void push(longint first, longint tap, bit [31:0] w, bit none, bit last);
            weight_item_t it;
            it.first_index   = first[15:0];
            it.tap           = tap[3:0];
            it.weight        = w;
            it.none_in_range = none;
            it.last          = last;
            pending.push_back(it);
        endfunction

        function void note_coord(bit [31:0] raw);
            longint c, dim, idx, base, fl, x, d1, d2, kstart, cnt, n, k, m, t, den;
            bit [63:0] num, dmag, dv, wmag;
            bit neg;
            c   = longint'(signed'(raw)) - 65536;
            dim = (row_len > 17'd65536) ? 65536 : row_len;
            if ((c & 16'hFFFF) == 0) begin
                idx = c / 65536;
                if (idx < 0 || idx >= dim) push(0, 0, 0, 1, 1);
                else push(idx, 0, ONE_Q24, 0, 1);
                return;
            end
            base = (taps % 2 != 0) ? c + 32768 : c;
            fl   = (base - longint'(base & 64'hFFFF)) / 65536;
            x    = c - fl * 65536;
            d1 = fl + k_first;
            kstart = k_first;
            if (d1 < 0) begin
                kstart = k_first - d1;
                d1 = 0;
            end
            d2 = fl + k_final;
            if (d2 > dim - 1) d2 = dim - 1;
            cnt = d2 - d1 + 1;
            if (cnt <= 0) begin
                push(0, 0, 0, 1, 1);
                return;
            end
            for (n = 0; n < cnt; n++) begin
                k = kstart + n;
                num = ONE_Q30;
                neg = 0;
                for (m = k_first; m <= k_final; m++) begin
                    if (m != k) begin
                        t = x - m * 65536;
                        if (t < 0) begin
                            neg = !neg;
                            num = scale_q16(num, -t);
                        end else begin
                            num = scale_q16(num, t);
                        end
                    end
                end
                den = den_tab[k - k_first];
                if (den < 0) begin
                    neg = !neg;
                    dmag = -den;
                end else begin
                    dmag = den;
                end
                if (dmag == 0) dmag = 1;
                dv = dmag << 6;
                wmag = (num + dv / 2) / dv;
                if (neg) begin
                    if (wmag > 64'h8000_0000) wmag = 64'h8000_0000;
                    push(d1, n, 32'(64'd0 - wmag), 0, n == cnt - 1);
                end else begin
                    if (wmag > 64'h7FFF_FFFF) wmag = 64'h7FFF_FFFF;
                    push(d1, n, wmag[31:0], 0, n == cnt - 1);
                end
            end
        endfunction

        function void check(weight_item_t got);
            weight_item_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [COORD_W-1:0] i_coord;
    logic                     o_valid;
    logic                     i_ready;
    logic [IDX_W-1:0]         o_first_index;
    logic [TAP_W-1:0]         o_tap;
    logic signed [WGT_W-1:0]  o_weight;
    logic                     o_none_in_range;
    logic                     o_last;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [ROW_W-1:0]         i_cfg_data;

    weight_board sb;
    longint      cycles;
    int          burst_left;

    lagrange_interp_weights_top u_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            sb.check('{o_first_index, o_tap, o_weight, o_none_in_range, o_last});

    // receiver stalls: phases of always-ready, coin-flip and long stalls
    int rx_mode, rx_cnt, rx_hold;
    always @(negedge i_clk) begin
        if (rx_cnt == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_cnt  = $urandom_range(20, 200);
        end
        rx_cnt--;
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            default: begin
                if (rx_hold == 0) rx_hold = $urandom_range(1, 25);
                rx_hold--;
                i_ready <= (rx_hold == 0);
            end
        endcase
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_coord(logic [31:0] coord);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge i_clk);
        end
        burst_left--;
        i_valid = 1'b1;
        i_coord = coord;
        do @(posedge i_clk); while (!o_ready);
        sb.note_coord(coord);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        int sel;
        longint dim, idx;
        sel = $urandom_range(0, 9);
        dim = (sb.row_len > 17'd65536) ? 65536 : sb.row_len;
        if (sel == 0) return $urandom();
        idx = longint'($urandom_range(0, 30)) - 12;
        if ($urandom_range(0, 1)) idx = idx + dim - 8;
        if (sel == 1) return 32'((idx + 1) << 16);
        return 32'(((idx + 1) << 16) + $urandom_range(1, 65535));
    endfunction

    logic [31:0] directed[] = '{
        32'h0001_0000, 32'h0100_0000, 32'h0101_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0000, 32'hFFFF_8000, 32'h0001_8000, 32'h0001_4000, 32'h0100_C000,
        32'h0000_0001, 32'hFFFF_FFFF, 32'h00FF_8000, 32'h0002_0001, 32'h0080_FFFF,
        32'h0000_8000, 32'h0101_8000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    int          ph_order[] = '{4, 1, 16, 0, 31, 2, 7, 16, 5, 3};
    int          ph_row[]   = '{256, 1, 65536, 0, 131071, 1, 3, 20, 70000, 2};

    initial begin
        sb = new();
        burst_left = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_coord = '0;
        i_ready = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_ORDER;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        foreach (directed[i]) send_coord(directed[i]);
        drain();

        foreach (ph_order[p]) begin
            write_reg(REG_ORDER, ROW_W'(ph_order[p]));
            write_reg(REG_ROW, ROW_W'(ph_row[p]));
            // half-way coordinate in a one-sample row: a lone tap or none in range, by order
            if (ph_row[p] == 1) send_coord(32'h0001_8000);
            repeat (31) send_coord(pick_coord());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* lagrange_interp_weights_top.f */
rtl/lgw_pkg.sv
rtl/lgw_ctrl.sv
rtl/lgw_dp.sv
rtl/lagrange_interp_weights_top.sv
rtl/lgw_chk.sv
tb/sv/lagrange_interp_weights_top_tb.sv
